// ===== src/assert_macros.svh =====
// Assertion helpers for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== src/hcbd_pkg.sv =====
package hcbd_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] status_type;

   localparam byte_type CHAR_CR = 8'h0d;
   localparam byte_type CHAR_LF = 8'h0a;

   localparam status_type STAT_RUN       = 3'd0;
   localparam status_type STAT_DONE      = 3'd1;
   localparam status_type STAT_BAD_DIGIT = 3'd2;
   localparam status_type STAT_NO_LF_SZ  = 3'd3;
   localparam status_type STAT_NO_CR_END = 3'd4;
   localparam status_type STAT_NO_LF_END = 3'd5;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(byte_type b);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.value = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.value = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.value = 4'(b - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

// ===== src/hcbd_channels.sv =====
interface hcbd_req_if import hcbd_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface hcbd_rsp_if import hcbd_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       payload_valid;
   byte_type   payload_byte;
   status_type status;

   modport source (output valid, output payload_valid, output payload_byte,
                   output status, input ready);
   modport sink (input valid, input payload_valid, input payload_byte,
                 input status, output ready);
endinterface

// ===== src/http_chunked_body_decoder_top.sv =====
// An accepted req word's rsp word is registered and is valid in the next cycle.
// Throughput: one word per cycle unless rsp stalls; the decode of a byte against the
// phase, size and remaining-count registers fits between input and output register.
// Reset (synchronous, active high): phase returns to size reading, size and
// remaining count clear, and the rsp register empties.
`include "assert_macros.svh"

module http_chunked_body_decoder_top import hcbd_pkg::*; #(
   parameter int SIZE_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   hcbd_req_if.sink   req,
   hcbd_rsp_if.source rsp
);

   localparam logic [3:0] PH_SIZE        = 4'd0;
   localparam logic [3:0] PH_LF_SIZE     = 4'd1;
   localparam logic [3:0] PH_DATA        = 4'd2;
   localparam logic [3:0] PH_CR_END      = 4'd3;
   localparam logic [3:0] PH_LF_END      = 4'd4;
   localparam logic [3:0] PH_DONE        = 4'd5;
   localparam logic [3:0] PH_ERR_DIGIT   = 4'd6;
   localparam logic [3:0] PH_ERR_LF_SIZE = 4'd7;
   localparam logic [3:0] PH_ERR_CR_END  = 4'd8;
   localparam logic [3:0] PH_ERR_LF_END  = 4'd9;

   logic [3:0]           phase_ff, phase_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [SIZE_BITS-1:0] left_ff, left_in;

   logic       rsp_valid_ff;
   logic       rsp_pvalid_ff, rsp_pvalid_in;
   byte_type   rsp_pbyte_ff, rsp_pbyte_in;
   status_type rsp_status_ff, rsp_status_in;

   logic     req_fire;
   byte_type b;
   hex_type  hex;
   logic     is_term;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_fire  = req.valid && req.ready;
   assign b         = req.data_byte;
   assign hex       = hex_decode(b);
   assign is_term   = (phase_ff == PH_DONE) || (phase_ff == PH_ERR_DIGIT) ||
                      (phase_ff == PH_ERR_LF_SIZE) || (phase_ff == PH_ERR_CR_END) ||
                      (phase_ff == PH_ERR_LF_END);

   always_comb begin
      phase_in      = phase_ff;
      size_in       = size_ff;
      left_in       = left_ff;
      rsp_pvalid_in = 1'b0;
      rsp_pbyte_in  = 8'd0;
      unique case (phase_ff)
         PH_SIZE: begin
            if (b == CHAR_CR) begin
               phase_in = PH_LF_SIZE;
            end else if (!hex.ok || size_ff[SIZE_BITS-1 -: 4] != 4'd0) begin
               // bad digit, or one more nibble would overflow the size
               phase_in = PH_ERR_DIGIT;
            end else begin
               size_in = {size_ff[SIZE_BITS-5:0], hex.value};
            end
         end
         PH_LF_SIZE: begin
            if (b != CHAR_LF) begin
               phase_in = PH_ERR_LF_SIZE;
            end else if (size_ff == '0) begin
               phase_in = PH_DONE;
            end else begin
               left_in  = size_ff;
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            rsp_pvalid_in = 1'b1;
            rsp_pbyte_in  = b;
            left_in       = left_ff - SIZE_BITS'(1);
            if (left_ff == SIZE_BITS'(1)) begin
               phase_in = PH_CR_END;
            end
         end
         PH_CR_END: begin
            phase_in = (b == CHAR_CR) ? PH_LF_END : PH_ERR_CR_END;
         end
         PH_LF_END: begin
            if (b == CHAR_LF) begin
               size_in  = '0;
               phase_in = PH_SIZE;
            end else begin
               phase_in = PH_ERR_LF_END;
            end
         end
         default: begin
            // terminal: ignore the byte
         end
      endcase

      unique case (phase_in)
         PH_DONE:        rsp_status_in = STAT_DONE;
         PH_ERR_DIGIT:   rsp_status_in = STAT_BAD_DIGIT;
         PH_ERR_LF_SIZE: rsp_status_in = STAT_NO_LF_SZ;
         PH_ERR_CR_END:  rsp_status_in = STAT_NO_CR_END;
         PH_ERR_LF_END:  rsp_status_in = STAT_NO_LF_END;
         default:        rsp_status_in = STAT_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SIZE;
         size_ff      <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff     <= phase_in;
            size_ff      <= size_in;
            left_ff      <= left_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_pvalid_ff <= rsp_pvalid_in;
         rsp_pbyte_ff  <= rsp_pbyte_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.payload_valid = rsp_pvalid_ff;
   assign rsp.payload_byte  = rsp_pbyte_ff;
   assign rsp.status        = rsp_status_ff;

   `ASSERT_IMPLIES(a_payload_running, clock, reset,
                   rsp_valid_ff && rsp_pvalid_ff, rsp_status_ff == STAT_RUN)
   `ASSERT_IMPLIES(a_data_count_nonzero, clock, reset, phase_ff == PH_DATA, left_ff != '0)
   `ASSERT_NEXT(a_terminal_holds, clock, reset, is_term, phase_ff == $past(phase_ff))
   `ASSERT_NEXT(a_data_gives_payload, clock, reset,
                req_fire && phase_ff == PH_DATA, rsp_valid_ff && rsp_pvalid_ff)

endmodule
